[design/skf_pkg.sv]
package skf_pkg;

    localparam int SKF_FRAC_BITS   = 16;
    localparam int SKF_DATA_WIDTH  = 32;
    localparam int SKF_CFG_INDEX_W = 4;

    localparam logic [SKF_CFG_INDEX_W-1:0] CFG_INITIAL_ESTIMATE  = SKF_CFG_INDEX_W'(0);
    localparam logic [SKF_CFG_INDEX_W-1:0] CFG_INITIAL_ERROR     = SKF_CFG_INDEX_W'(1);
    localparam logic [SKF_CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE = SKF_CFG_INDEX_W'(2);
    localparam logic [SKF_CFG_INDEX_W-1:0] CFG_PROCESS_NOISE     = SKF_CFG_INDEX_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } skf_state_t;

endpackage

[design/scalar_kalman_filter_core.sv]
// Channel  Direction  Ports                               Content
// s_       in         s_tvalid s_tready s_tdata           measurement
// m_       out        m_tvalid m_tready m_tdata           filtered_value, gain, error_covariance
// cfg_     in         cfg_valid cfg_ready cfg_index/data  register writes, always ready
//
// An item is captured at its accepting edge; the divider then forms the gain, the two shift-add
// multipliers form the products, and an update writes the new estimate and error. The next
// item is accepted in the cycle after the update.
// Reset and every configuration write load the estimate and error from the initial registers.
// A stalled result holds in the output register; the update waits until that register is free.
module scalar_kalman_filter_core
    import skf_pkg::*;
#(
    parameter int FRAC_BITS  = SKF_FRAC_BITS,
    parameter int DATA_WIDTH = SKF_DATA_WIDTH
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // measurement
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // filtered_value, gain, error_covariance
    output logic [((2*DATA_WIDTH+FRAC_BITS+8)/8)*8-1:0] m_tdata,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [SKF_CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [DATA_WIDTH-1:0]                      cfg_data
);

    localparam int DW        = DATA_WIDTH;
    localparam int F         = FRAC_BITS;
    localparam int M_TDATA_W = ((2*DATA_WIDTH+FRAC_BITS+8)/8)*8;
    localparam int CNT_W     = $clog2(F);
    localparam logic [DW-1:0] RST_ERROR  = DW'(1) << F;
    localparam logic [DW-1:0] RST_RNOISE = DW'(1) << F;
    localparam logic [DW-1:0] RST_QNOISE = DW'((2**F) / 100);
    localparam logic [F:0]    GAIN_ONE   = (F+1)'(1) << F;

    skf_state_t state_reg, state_next;

    logic [DW-1:0]    init_est_reg, init_err_reg, r_noise_reg, q_noise_reg;
    logic [DW-1:0]    est_reg, err_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW:0]      sum_reg;
    logic [DW+1:0]    rem_reg;
    logic [F-1:0]     quo_reg;
    logic             zero_sum_reg, r_zero_reg, neg_reg;
    logic [DW:0]      mag_reg;
    logic [F:0]       gain_reg;
    logic [F-1:0]     gsh_reg, gcsh_reg;
    logic [DW:0]      acc1_reg;
    logic [DW-1:0]    acc2_reg;
    logic             m_valid_reg;
    logic [DW-1:0]    out_est_reg, out_err_reg;
    logic [F:0]       out_gain_reg;

    logic           accept, div_en, mul_en, fin_fire, cnt_last, cfg_hit;
    logic [DW-1:0]  meas;
    logic [DW:0]    diff, sum_now;
    logic [DW+1:0]  rem_sh, rem_next;
    logic           quo_bit;
    logic [F-1:0]   quo_next;
    logic [F:0]     gain_now, gain_cmp;
    logic [DW+1:0]  add1;
    logic [DW:0]    add2;
    logic [DW:0]    step, est_ext, est_new;
    logic [DW-1:0]  prod2;
    logic [DW:0]    err_sum;
    logic [DW-1:0]  err_new;

    assign cnt_last  = (cnt_reg == '0);
    assign cfg_ready = 1'b1;
    assign meas      = s_tdata[DW-1:0];
    assign diff      = {meas[DW-1], meas} - {est_reg[DW-1], est_reg};
    assign sum_now   = {1'b0, err_reg} + {1'b0, r_noise_reg};

    // Restoring division, one quotient bit per cycle.
    assign rem_sh   = {rem_reg[DW:0], 1'b0};
    assign quo_bit  = (rem_sh >= {1'b0, sum_reg});
    assign rem_next = quo_bit ? (rem_sh - {1'b0, sum_reg}) : rem_sh;
    assign quo_next = {quo_reg[F-2:0], quo_bit};

    always_comb begin
        if (zero_sum_reg) begin
            gain_now = '0;
        end else if (r_zero_reg) begin
            gain_now = GAIN_ONE;
        end else begin
            gain_now = {1'b0, quo_next};
        end
    end
    assign gain_cmp = GAIN_ONE - gain_now;

    // Shift-add multipliers, least significant gain bit first, low product bits dropped.
    assign add1 = {1'b0, acc1_reg} + (gsh_reg[0] ? {1'b0, mag_reg} : '0);
    assign add2 = {1'b0, acc2_reg} + (gcsh_reg[0] ? {1'b0, err_reg} : '0);

    assign step    = gain_reg[F] ? mag_reg : acc1_reg;
    assign prod2   = (gain_reg == '0) ? err_reg : acc2_reg;
    assign est_ext = {est_reg[DW-1], est_reg};
    assign est_new = neg_reg ? (est_ext - step) : (est_ext + step);
    assign err_sum = {1'b0, prod2} + {1'b0, q_noise_reg};
    assign err_new = err_sum[DW] ? '1 : err_sum[DW-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (cnt_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        div_en   = 1'b0;
        mul_en   = 1'b0;
        fin_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DIV:  div_en   = 1'b1;
            ST_MUL:  mul_en   = 1'b1;
            ST_FIN:  fin_fire = !m_valid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (cfg_index) inside
            CFG_INITIAL_ESTIMATE, CFG_INITIAL_ERROR,
            CFG_MEASUREMENT_NOISE, CFG_PROCESS_NOISE: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            init_est_reg <= '0;
            init_err_reg <= RST_ERROR;
            r_noise_reg  <= RST_RNOISE;
            q_noise_reg  <= RST_QNOISE;
            est_reg      <= '0;
            err_reg      <= RST_ERROR;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_hit) begin
                unique case (cfg_index)
                    CFG_INITIAL_ESTIMATE: begin
                        init_est_reg <= cfg_data;
                        est_reg      <= cfg_data;
                        err_reg      <= init_err_reg;
                    end
                    CFG_INITIAL_ERROR: begin
                        init_err_reg <= cfg_data;
                        est_reg      <= init_est_reg;
                        err_reg      <= cfg_data;
                    end
                    CFG_MEASUREMENT_NOISE: begin
                        r_noise_reg <= cfg_data;
                        est_reg     <= init_est_reg;
                        err_reg     <= init_err_reg;
                    end
                    CFG_PROCESS_NOISE: begin
                        q_noise_reg <= cfg_data;
                        est_reg     <= init_est_reg;
                        err_reg     <= init_err_reg;
                    end
                    default: begin
                        est_reg <= init_est_reg;
                        err_reg <= init_err_reg;
                    end
                endcase
            end else if (fin_fire) begin
                est_reg <= est_new[DW-1:0];
                err_reg <= err_new;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cnt_reg      <= CNT_W'(F - 1);
            sum_reg      <= sum_now;
            rem_reg      <= {2'b00, err_reg};
            quo_reg      <= '0;
            zero_sum_reg <= (sum_now == '0);
            r_zero_reg   <= (r_noise_reg == '0);
            neg_reg      <= diff[DW];
            mag_reg      <= diff[DW] ? (~diff + (DW+1)'(1)) : diff;
        end else if (div_en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_last) begin
                cnt_reg  <= CNT_W'(F - 1);
                gain_reg <= gain_now;
                gsh_reg  <= gain_now[F-1:0];
                gcsh_reg <= gain_cmp[F-1:0];
                acc1_reg <= '0;
                acc2_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end else if (mul_en) begin
            acc1_reg <= add1[DW+1:1];
            acc2_reg <= add2[DW:1];
            gsh_reg  <= gsh_reg >> 1;
            gcsh_reg <= gcsh_reg >> 1;
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (fin_fire) begin
            out_est_reg  <= est_new[DW-1:0];
            out_gain_reg <= gain_reg;
            out_err_reg  <= err_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_err_reg, out_gain_reg, out_est_reg});

endmodule

[design/skf_checker.sv]
module skf_checker
    import skf_pkg::*;
#(
    parameter int FRAC_BITS  = SKF_FRAC_BITS,
    parameter int DATA_WIDTH = SKF_DATA_WIDTH
) (
    input logic                                        aclk,
    input logic                                        aresetn,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [((2*DATA_WIDTH+FRAC_BITS+8)/8)*8-1:0] m_tdata,
    input logic                                        cfg_ready
);

    localparam logic [FRAC_BITS:0] GAIN_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // The filter works on one item at a time, so it is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while the filter was still busy");

    // When no result is pending, an accept is not followed straight away by a result.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early after an accept");

    // The gain never exceeds 1.0.
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DATA_WIDTH+FRAC_BITS:DATA_WIDTH] <= GAIN_ONE)
        else $error("gain above one");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind scalar_kalman_filter_core skf_checker #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_WIDTH(DATA_WIDTH)
) u_skf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);
